// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes for the sorted threat table
// Operation codes, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam logic [2:0] OP_ADD_DAMAGE = 3'd0;
   localparam logic [2:0] OP_ADD_VALUE  = 3'd1;
   localparam logic [2:0] OP_REMOVE     = 3'd2;
   localparam logic [2:0] OP_REMOVE_HD  = 3'd3;
   localparam logic [2:0] OP_EXPIRE     = 3'd4;
   localparam logic [2:0] OP_QUERY      = 3'd5;

   localparam logic REG_MAX_ENTRIES = 1'b0;
   localparam logic REG_MEMORY_TIME = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_TRIM,
      ST_INSERT,
      ST_MOVE,
      ST_RESP
   } state_type;

   // one slot of the table
   typedef struct packed {
      logic [31:0] target;
      logic [31:0] value;
      logic [31:0] stamp;
   } entry_type;

endpackage

// ----- rtl/stt_cell.sv -----
// ----------------------------------------------------------------------------
// stt_cell: one slot of the threat table chain
// Holds an entry and loads own, left-neighbor, right-neighbor or new data.
// ----------------------------------------------------------------------------
module stt_cell
   import stt_pkg::*;
(
   input  logic      clock,
   input  logic [1:0] sel,    // 0 hold, 1 take left (i-1), 2 take right (i+1), 3 load
   input  entry_type left,
   input  entry_type right,
   input  entry_type load,
   output entry_type q
);
   entry_type q_ff;
   entry_type q_in;

   always_comb begin
      case (sel)
         2'd1:    q_in = left;
         2'd2:    q_in = right;
         2'd3:    q_in = load;
         default: q_in = q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;
endmodule

// ----- rtl/sorted_threat_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_threat_table_top: bounded target table sorted by threat value
// Chain of slot cells with a small sequencer for search, shift and expiry.
// ----------------------------------------------------------------------------
// Usage:
//   req_ words carry one operation (add damage, add value, remove target,
//   remove head, expire old, query); each gives exactly one rsp_ word with
//   the found flag, the head target and the entry count.
//   csr_ writes set max_entries (index 0) and memory_time_ms (index 1);
//   write them only while no request is in flight.
// Sequencing:
//   One request at a time; req_tready is high only while idle. The id
//   search is a parallel compare across the cell row. A query, a remove,
//   an ignored add or an expire goes from the decision step to the
//   response, an expire first sweeping out every expired entry; an add to
//   a known target writes the sum in place and then moves the entry slot
//   by slot to its sorted place; an add of a new target first expires or
//   drops entries as needed, then inserts it. The next request can be
//   taken in the cycle after the response word is loaded.
// Reset clears the count and the sequencer; slot contents stay undefined
// and are never read beyond the count. When the receiver stalls the
// response holds in its register; one more request may be taken and
// worked, but its word waits until the held word is taken.
// ----------------------------------------------------------------------------
module sorted_threat_table_top
   import stt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[2:0], target_id[34:3], amount[66:35], now_ms[98:67], zero pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // found[0], head_valid[1], head_target[33:2], entry_count[38:34], zero pad
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [4:0]    max_ff;
   logic [31:0]   mem_time_ff;
   logic [2:0]    op_ff;
   logic [31:0]   id_ff, amt_ff, now_ff;
   logic          found_ff, found_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic          up_ff, up_in;
   logic [39:0]   rsp_ff;
   logic          rsp_valid_ff;

   entry_type cell_q [CAPACITY];
   logic [1:0] cell_sel [CAPACITY];
   entry_type load_e;

   // the row of slot cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type lft, rgt;
      if (i == 0) begin : g_l0
         assign lft = cell_q[0];
      end else begin : g_l
         assign lft = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_rn
         assign rgt = cell_q[i];
      end else begin : g_r
         assign rgt = cell_q[i+1];
      end
      stt_cell u_cell (
         .clock (clock),
         .sel   (cell_sel[i]),
         .left  (lft),
         .right (rgt),
         .load  (load_e),
         .q     (cell_q[i])
      );
   end

   // per-cell compare results
   logic [CAPACITY-1:0] live, hit, expd, bigger;
   logic [CW-1:0] limit;
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         live[i]   = CW'(i) < count_ff;
         hit[i]    = live[i] && cell_q[i].target == id_ff;
         expd[i]   = live[i] && (now_ff - cell_q[i].stamp) > mem_time_ff;
         bigger[i] = live[i] && $signed(cell_q[i].value) > $signed(amt_ff);
      end
      if (max_ff == 5'd0) limit = CW'(1);
      else if ({27'd0, max_ff} > CAPACITY) limit = CW'(CAPACITY);
      else limit = CW'(max_ff);
   end

   // first hit, first expired, and insert slot (first entry not bigger;
   // the row is sorted, so bigger entries form a prefix)
   logic          any_hit, any_exp;
   logic [IW-1:0] hit_pos, exp_pos;
   logic [CW-1:0] ins_pos;
   always_comb begin
      any_hit = 1'b0; any_exp = 1'b0;
      hit_pos = '0; exp_pos = '0; ins_pos = CW'(CAPACITY);
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit[i])  begin any_hit = 1'b1; hit_pos = IW'(i); end
         if (expd[i]) begin any_exp = 1'b1; exp_pos = IW'(i); end
         if (!bigger[i]) ins_pos = CW'(i);
      end
   end

   // saturated sum for the hit entry
   logic signed [32:0] sum;
   logic [31:0]        sat;
   always_comb begin
      sum = 33'($signed(cell_q[hit_pos].value)) + 33'($signed(amt_ff));
      if (sum > 33'sd2147483647) sat = 32'h7FFF_FFFF;
      else if (sum < -33'sd2147483648) sat = 32'h8000_0000;
      else sat = sum[31:0];
   end

   logic accept, ignored, is_add;
   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign is_add     = op_ff == OP_ADD_DAMAGE || op_ff == OP_ADD_VALUE;
   assign ignored    = (op_ff == OP_ADD_DAMAGE) ? ($signed(amt_ff) <= 0) : (amt_ff == '0);

   logic [IW-1:0] nxt;
   assign nxt = up_ff ? pos_ff - IW'(1) : pos_ff + IW'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      up_in    = up_ff;
      load_e   = '{target: id_ff, value: amt_ff, stamp: now_ff};
      for (int i = 0; i < CAPACITY; i++) cell_sel[i] = 2'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXPIRE;
               found_in = 1'b0;
            end
         end
         ST_EXPIRE: begin
            // first cycle decides; for an expire, later cycles sweep the remaining expired entries
            state_in = ST_RESP;
            if (is_add && !ignored && !found_ff) begin
               if (any_hit) begin
                  found_in = 1'b1;
                  load_e = '{target: id_ff, value: sat, stamp: now_ff};
                  cell_sel[hit_pos] = 2'd3;
                  pos_in = hit_pos;
                  up_in  = !amt_ff[31];
                  state_in = ST_MOVE;
               end else if (op_ff == OP_ADD_VALUE && count_ff >= limit) begin
                  state_in = ST_TRIM;
                  found_in = 1'b0;
                  // reuse expiry sweep: mark by up_ff
                  up_in = 1'b1;
               end else begin
                  state_in = ST_TRIM;
                  up_in = 1'b0;
               end
            end else if (op_ff == OP_REMOVE && any_hit) begin
               found_in = 1'b1;
               for (int i = 0; i < CAPACITY; i++)
                  if (CW'(i) >= CW'(hit_pos)) cell_sel[i] = 2'd2;
               count_in = count_ff - CW'(1);
            end else if (op_ff == OP_REMOVE_HD && count_ff != '0) begin
               found_in = 1'b1;
               for (int i = 0; i < CAPACITY; i++) cell_sel[i] = 2'd2;
               count_in = count_ff - CW'(1);
            end else if (op_ff == OP_EXPIRE && any_exp) begin
               for (int i = 0; i < CAPACITY; i++)
                  if (CW'(i) >= CW'(exp_pos)) cell_sel[i] = 2'd2;
               count_in = count_ff - CW'(1);
               state_in = ST_EXPIRE;
            end
            if (op_ff == OP_EXPIRE) found_in = any_exp;
         end
         ST_TRIM: begin
            // up_ff set: expire one per cycle first, then drop tail
            if (up_ff && any_exp) begin
               for (int i = 0; i < CAPACITY; i++)
                  if (CW'(i) >= CW'(exp_pos)) cell_sel[i] = 2'd2;
               count_in = count_ff - CW'(1);
            end else if (count_ff >= limit && count_ff != '0) begin
               up_in = 1'b0;
               count_in = count_ff - CW'(1);
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (CW'(i) == ins_pos) cell_sel[i] = 2'd3;
               else if (CW'(i) > ins_pos) cell_sel[i] = 2'd1;
            end
            count_in = count_ff + CW'(1);
            state_in = ST_RESP;
         end
         ST_MOVE: begin
            if (up_ff ? (pos_ff != '0 &&
                         $signed(cell_q[pos_ff].value) > $signed(cell_q[nxt].value))
                      : (CW'(pos_ff) + CW'(1) < count_ff &&
                         $signed(cell_q[nxt].value) > $signed(cell_q[pos_ff].value))) begin
               cell_sel[pos_ff] = up_ff ? 2'd1 : 2'd2;
               cell_sel[nxt]    = up_ff ? 2'd2 : 2'd1;
               pos_in = nxt;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         max_ff       <= 5'd16;
         mem_time_ff  <= 32'd10000;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         found_ff <= found_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_MAX_ENTRIES) max_ff <= csr_data[4:0];
            if (csr_index == REG_MEMORY_TIME) mem_time_ff <= csr_data;
         end
         if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      up_ff  <= up_in;
      if (accept) begin
         op_ff  <= req_tdata[2:0];
         id_ff  <= req_tdata[34:3];
         amt_ff <= req_tdata[66:35];
         now_ff <= req_tdata[98:67];
      end
      if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_tready)) begin
         rsp_ff <= {1'b0, 5'(count_ff), (count_ff != '0) ? cell_q[0].target : 32'd0,
                    count_ff != '0, found_ff && op_ff != OP_EXPIRE};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
endmodule
